[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion forms for the compass supervisor core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold on every clock edge out of reset
`define CHCS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define CHCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[sv/chcs_pkg.sv]
// ----------------------------------------------------------------------------
// chcs_pkg
// shared types, constants and helpers of the compass heading supervisor
// ----------------------------------------------------------------------------
package chcs_pkg;

    // default timestamp width
    localparam int TIME_BITS_DEF = 32;

    // heading scale: 1/4096 degree internally
    localparam logic [20:0] FULL_TURN = 21'd1474560;
    localparam logic [20:0] HALF_TURN = 21'd737280;
    localparam logic [20:0] OCT_HALF  = 21'd92160;
    localparam logic [20:0] OCT_STEP  = 21'd184320;
    localparam logic [12:0] RAW_LIMIT = 13'd5760;

    // calibration modes
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_AUTO   = 2'd1;
    localparam logic [1:0] MODE_MANUAL = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_START_CAL  = 3'd0;
    localparam logic [2:0] CFG_STABLE_MS  = 3'd1;
    localparam logic [2:0] CFG_WARN_MS    = 3'd2;
    localparam logic [2:0] CFG_CHECK_MS   = 3'd3;
    localparam logic [2:0] CFG_SYS_THR    = 3'd4;
    localparam logic [2:0] CFG_MAG_THR    = 3'd5;
    localparam logic [2:0] CFG_ALPHA      = 3'd6;

    // register reset values
    localparam logic [15:0] STABLE_MS_RST = 16'd3000;
    localparam logic [15:0] WARN_MS_RST   = 16'd5000;
    localparam logic [15:0] CHECK_MS_RST  = 16'd500;
    localparam logic [1:0]  SYS_THR_RST   = 2'd2;
    localparam logic [1:0]  MAG_THR_RST   = 2'd2;
    localparam logic [15:0] ALPHA_RST     = 16'd6554;

    // configuration register set
    typedef struct packed {
        logic [15:0] stable_ms;
        logic [15:0] warn_ms;
        logic [15:0] check_ms;
        logic [1:0]  sys_thr;
        logic [1:0]  mag_thr;
        logic [15:0] alpha;
    } t_cfg;

    // calibration load request from the register port
    typedef struct packed {
        logic load;
        logic calibrated;
    } t_cal_load;

    // per-request control inputs of the supervisor
    typedef struct packed {
        logic [7:0] levels;
        logic       req_manual;
        logic       cancel;
    } t_sup_req;

    // supervisor status towards the result port
    typedef struct packed {
        logic [1:0] mode;
        logic       warn;
        logic       loaded;
        logic       full;
        logic       save;
        logic [7:0] levels;
    } t_sup_status;

    // octant from internal heading, boundaries at 22.5 + k*45 degrees
    function automatic logic [2:0] chcs_octant(input logic [20:0] acc);
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int k = 1; k <= 8; k++) begin
            if (acc >= 21'(k * OCT_STEP - OCT_HALF)) begin
                cnt = cnt + 4'd1;
            end
        end
        return cnt[2:0];
    endfunction

endpackage

[sv/chcs_filter.sv]
// ----------------------------------------------------------------------------
// chcs_filter
// circular exponential heading filter with wrap at a full turn
// ----------------------------------------------------------------------------
module chcs_filter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic [12:0] i_raw,
    input  logic [15:0] i_alpha,
    output logic [20:0] o_acc
);

    localparam logic signed [21:0] S_FULL = $signed({1'b0, chcs_pkg::FULL_TURN});
    localparam logic signed [21:0] S_HALF = $signed({1'b0, chcs_pkg::HALF_TURN});

    logic        r_seeded;
    logic [20:0] r_acc;
    logic        n_seeded;
    logic [20:0] n_acc;

    logic [20:0]        w_target;
    logic signed [21:0] w_diff;
    logic signed [21:0] w_diff_wrap;
    logic [19:0]        w_mag;
    logic [35:0]        w_prod;
    logic [35:0]        w_round;
    logic [19:0]        w_step_mag;
    logic signed [22:0] w_step;
    logic signed [22:0] w_sum;
    logic signed [22:0] w_sum_wrap;
    logic               w_valid;

    // difference to target, wrapped to half a turn
    always_comb begin
        w_valid  = i_raw < chcs_pkg::RAW_LIMIT;
        w_target = {i_raw, 8'd0};
        w_diff   = $signed({1'b0, w_target}) - $signed({1'b0, r_acc});
        if (w_diff > S_HALF) begin
            w_diff_wrap = w_diff - S_FULL;
        end else if (w_diff < -S_HALF) begin
            w_diff_wrap = w_diff + S_FULL;
        end else begin
            w_diff_wrap = w_diff;
        end
        w_mag = w_diff_wrap[21] ? 20'(-w_diff_wrap) : 20'(w_diff_wrap);
    end

    // scaled step, rounded half away from zero
    always_comb begin
        w_prod     = 36'(w_mag) * 36'(i_alpha);
        w_round    = w_prod + 36'd32768;
        w_step_mag = w_round[36-1:16];
        w_step     = w_diff_wrap[21] ? -$signed({3'b000, w_step_mag})
                                     : $signed({3'b000, w_step_mag});
        w_sum      = $signed({2'b00, r_acc}) + w_step;
        if (w_sum < 23'sd0) begin
            w_sum_wrap = w_sum + $signed({2'b00, chcs_pkg::FULL_TURN});
        end else if (w_sum >= $signed({2'b00, chcs_pkg::FULL_TURN})) begin
            w_sum_wrap = w_sum - $signed({2'b00, chcs_pkg::FULL_TURN});
        end else begin
            w_sum_wrap = w_sum;
        end
    end

    // seed on first valid sample, then track
    always_comb begin
        n_seeded = r_seeded;
        n_acc    = r_acc;
        if (w_valid) begin
            n_seeded = 1'b1;
            n_acc    = r_seeded ? 21'(w_sum_wrap) : w_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded <= 1'b0;
            r_acc    <= 21'd0;
        end else if (i_step) begin
            r_seeded <= n_seeded;
            r_acc    <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

[sv/chcs_supervisor.sv]
// ----------------------------------------------------------------------------
// chcs_supervisor
// calibration mode machine, level latch, stability timer and warning
// ----------------------------------------------------------------------------
module chcs_supervisor #(
    parameter int TIME_BITS = chcs_pkg::TIME_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  logic [TIME_BITS-1:0]   i_now,
    input  chcs_pkg::t_sup_req     i_req,
    input  chcs_pkg::t_cfg         i_cfg,
    input  chcs_pkg::t_cal_load    i_cal_load,
    output chcs_pkg::t_sup_status  o_status
);

    logic [1:0]           r_mode;
    logic                 r_loaded;
    logic                 r_seen;
    logic [TIME_BITS-1:0] r_start;
    logic [TIME_BITS-1:0] r_last_check;
    logic [TIME_BITS-1:0] r_last_warn;
    logic                 r_warn;
    logic [7:0]           r_levels;
    logic                 r_save;

    logic [1:0]           n_mode;
    logic                 n_loaded;
    logic                 n_seen;
    logic [TIME_BITS-1:0] n_start;
    logic [TIME_BITS-1:0] n_last_check;
    logic [TIME_BITS-1:0] n_last_warn;
    logic                 n_warn;
    logic [7:0]           n_levels;
    logic                 n_save;

    logic [TIME_BITS-1:0] w_since_check;
    logic [TIME_BITS-1:0] w_since_stable;
    logic [TIME_BITS-1:0] w_since_warn;

    // elapsed times, modulo the timestamp width
    assign w_since_check  = i_now - r_last_check;
    assign w_since_stable = i_now - r_start;
    assign w_since_warn   = i_now - r_last_warn;

    // next state for one request
    always_comb begin
        n_mode       = r_mode;
        n_loaded     = r_loaded;
        n_seen       = r_seen;
        n_start      = r_start;
        n_last_check = r_last_check;
        n_last_warn  = r_last_warn;
        n_warn       = r_warn;
        n_levels     = r_levels;
        n_save       = 1'b0;

        // manual flags, cancel wins
        if (i_req.cancel) begin
            if (r_mode inside {chcs_pkg::MODE_AUTO, chcs_pkg::MODE_MANUAL}) begin
                n_mode = chcs_pkg::MODE_NORMAL;
            end
        end else if (i_req.req_manual && (r_mode != chcs_pkg::MODE_MANUAL)) begin
            n_mode = chcs_pkg::MODE_MANUAL;
            n_seen = 1'b0;
        end

        // periodic level latch and stability timer
        if (w_since_check > TIME_BITS'(i_cfg.check_ms)) begin
            n_last_check = i_now;
            n_levels     = i_req.levels;
            if (n_mode inside {chcs_pkg::MODE_AUTO, chcs_pkg::MODE_MANUAL}) begin
                if (i_req.levels == 8'hFF) begin
                    if (!n_seen) begin
                        n_seen  = 1'b1;
                        n_start = i_now;
                    end else if (w_since_stable >= TIME_BITS'(i_cfg.stable_ms)) begin
                        n_save = 1'b1;
                        if (n_mode == chcs_pkg::MODE_AUTO) begin
                            n_loaded = 1'b1;
                        end
                        n_mode = chcs_pkg::MODE_NORMAL;
                    end
                end else begin
                    n_seen = 1'b0;
                end
            end
        end

        // poor calibration warning in normal mode
        if ((n_mode == chcs_pkg::MODE_NORMAL) &&
            (w_since_warn >= TIME_BITS'(i_cfg.warn_ms))) begin
            n_last_warn = i_now;
            n_warn      = (n_levels[1:0] < i_cfg.sys_thr) ||
                          (n_levels[7:6] < i_cfg.mag_thr);
        end
    end

    // state registers, calibration load from the register port first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= chcs_pkg::MODE_AUTO;
            r_loaded     <= 1'b0;
            r_seen       <= 1'b0;
            r_start      <= '0;
            r_last_check <= '0;
            r_last_warn  <= '0;
            r_warn       <= 1'b0;
            r_levels     <= 8'd0;
            r_save       <= 1'b0;
        end else if (i_cal_load.load) begin
            r_mode   <= i_cal_load.calibrated ? chcs_pkg::MODE_NORMAL : chcs_pkg::MODE_AUTO;
            r_loaded <= i_cal_load.calibrated;
        end else if (i_step) begin
            r_mode       <= n_mode;
            r_loaded     <= n_loaded;
            r_seen       <= n_seen;
            r_start      <= n_start;
            r_last_check <= n_last_check;
            r_last_warn  <= n_last_warn;
            r_warn       <= n_warn;
            r_levels     <= n_levels;
            r_save       <= n_save;
        end
    end

    // status out
    always_comb begin
        o_status.mode   = r_mode;
        o_status.warn   = r_warn;
        o_status.loaded = r_loaded;
        o_status.full   = r_levels == 8'hFF;
        o_status.save   = r_save;
        o_status.levels = r_levels;
    end

endmodule

[sv/compass_heading_calibration_supervisor_core.sv]
// ----------------------------------------------------------------------------
// compass_heading_calibration_supervisor_core
// heading filter and calibration supervisor, one sensor update per request
// ----------------------------------------------------------------------------
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+-----------------------------------
//  in       | in  | i_in_valid / o_in_ready | heading, time, levels, flags
//  out      | out | o_out_valid/i_out_ready | heading, octant, mode, flags, levels
//  cfg      | in  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  a request passes through the input register and then the result
//  registers; one request per cycle sustained while the result is taken
//  the filter step (one 20x16 multiply and wrap) sets the cycle path
//  synchronous active-low reset; no clearing pass
//  a stalled result holds and the input register still fills behind it
//  register writes are taken in any cycle, ready is always high
`include "assert_macros.svh"

module compass_heading_calibration_supervisor_core #(
    parameter int TIME_BITS = chcs_pkg::TIME_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [12:0] i_heading_raw,
    input  logic [31:0] i_time_ms,
    input  logic [1:0]  i_level_system,
    input  logic [1:0]  i_level_gyro,
    input  logic [1:0]  i_level_accel,
    input  logic [1:0]  i_level_magnet,
    input  logic        i_request_manual,
    input  logic        i_cancel_calibration,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [12:0] o_heading_filtered,
    output logic [2:0]  o_compass_octant,
    output logic [1:0]  o_calib_mode,
    output logic        o_warning_active,
    output logic        o_calib_loaded,
    output logic        o_fully_calibrated,
    output logic        o_save_pulse,
    output logic [1:0]  o_latched_system,
    output logic [1:0]  o_latched_gyro,
    output logic [1:0]  o_latched_accel,
    output logic [1:0]  o_latched_magnet,
    // register port
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // input register
    logic                 r_s1_valid;
    logic [12:0]          r_raw;
    logic [TIME_BITS-1:0] r_time;
    logic [7:0]           r_levels;
    logic                 r_req;
    logic                 r_cancel;
    logic                 r_out_valid;

    // configuration
    chcs_pkg::t_cfg        r_cfg;
    chcs_pkg::t_cal_load   w_cal_load;
    chcs_pkg::t_sup_req    w_sup_req;
    chcs_pkg::t_sup_status w_status;

    logic        w_adv;
    logic        w_step;
    logic        w_cfg_wr;
    logic [20:0] w_acc;

    // flow control
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_adv;
    assign w_step     = r_s1_valid && w_adv;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    // input register stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_raw    <= i_heading_raw;
            r_time   <= i_time_ms[TIME_BITS-1:0];
            r_levels <= {i_level_magnet, i_level_accel, i_level_gyro, i_level_system};
            r_req    <= i_request_manual;
            r_cancel <= i_cancel_calibration;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stable_ms <= chcs_pkg::STABLE_MS_RST;
            r_cfg.warn_ms   <= chcs_pkg::WARN_MS_RST;
            r_cfg.check_ms  <= chcs_pkg::CHECK_MS_RST;
            r_cfg.sys_thr   <= chcs_pkg::SYS_THR_RST;
            r_cfg.mag_thr   <= chcs_pkg::MAG_THR_RST;
            r_cfg.alpha     <= chcs_pkg::ALPHA_RST;
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                chcs_pkg::CFG_STABLE_MS: r_cfg.stable_ms <= i_cfg_data;
                chcs_pkg::CFG_WARN_MS:   r_cfg.warn_ms   <= i_cfg_data;
                chcs_pkg::CFG_CHECK_MS:  r_cfg.check_ms  <= i_cfg_data;
                chcs_pkg::CFG_SYS_THR:   r_cfg.sys_thr   <= i_cfg_data[1:0];
                chcs_pkg::CFG_MAG_THR:   r_cfg.mag_thr   <= i_cfg_data[1:0];
                chcs_pkg::CFG_ALPHA:     r_cfg.alpha     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stored calibration flag goes straight to the mode machine
    assign w_cal_load.load       = w_cfg_wr && (i_cfg_index == chcs_pkg::CFG_START_CAL);
    assign w_cal_load.calibrated = i_cfg_data[0];

    assign w_sup_req.levels     = r_levels;
    assign w_sup_req.req_manual = r_req;
    assign w_sup_req.cancel     = r_cancel;

    // heading filter
    chcs_filter u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_raw   (r_raw),
        .i_alpha (r_cfg.alpha),
        .o_acc   (w_acc)
    );

    // calibration supervisor
    chcs_supervisor #(
        .TIME_BITS (TIME_BITS)
    ) u_supervisor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_now      (r_time),
        .i_req      (w_sup_req),
        .i_cfg      (r_cfg),
        .i_cal_load (w_cal_load),
        .o_status   (w_status)
    );

    // result fields
    assign o_out_valid        = r_out_valid;
    assign o_heading_filtered = w_acc[20:8];
    assign o_compass_octant   = chcs_pkg::chcs_octant(w_acc);
    assign o_calib_mode       = w_status.mode;
    assign o_warning_active   = w_status.warn;
    assign o_calib_loaded     = w_status.loaded;
    assign o_fully_calibrated = w_status.full;
    assign o_save_pulse       = w_status.save;
    assign o_latched_system   = w_status.levels[1:0];
    assign o_latched_gyro     = w_status.levels[3:2];
    assign o_latched_accel    = w_status.levels[5:4];
    assign o_latched_magnet   = w_status.levels[7:6];

    // checks
    `CHCS_ASSERT(a_acc_in_turn, i_clk, i_rst_n, w_acc < chcs_pkg::FULL_TURN, "heading beyond full turn")
    `CHCS_ASSERT_IMPL(a_save_full, i_clk, i_rst_n, o_save_pulse, o_fully_calibrated, "save without full calibration")
    `CHCS_ASSERT_IMPL(a_stall_held, i_clk, i_rst_n, !o_in_ready, o_out_valid && !i_out_ready, "input stalled without held result")

endmodule
